/* hdl/isa_pkg.sv */
// Shared types and constants for the indexed shift array.
`timescale 1ns / 1ps
`default_nettype none

package isa_pkg;

  // Storage geometry.
  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Fixed field widths of the stream words.
  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 5;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 40;

  // Width used when an index is compared against the fill count.
  localparam int CMP_W = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_SET    = 3'd1,
    ACT_GET    = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_PUSH   = 3'd4,
    ACT_POP    = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // What one cell does at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_LOAD    = 2'd1,
    CELL_FROM_LO = 2'd2,
    CELL_FROM_HI = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    word_t    load;
  } cell_ctrl_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value_out;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    status_t             status;
  } result_t;

endpackage

`default_nettype wire

/* hdl/isa_cell.sv */
// One storage cell of the shift chain: holds a word, loads, or takes a neighbor's word.
`timescale 1ns / 1ps
`default_nettype none

module isa_cell
  import isa_pkg::*;
(
  input  wire logic       clk,
  input  cell_ctrl_t      ctrl,
  input  word_t           lo_word,
  input  word_t           hi_word,
  output word_t           word
);

  word_t data;

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD:    data <= data;
      CELL_LOAD:    data <= ctrl.load;
      CELL_FROM_LO: data <= lo_word;
      CELL_FROM_HI: data <= hi_word;
      default:      data <= data;
    endcase
  end

  assign word = data;

endmodule

`default_nettype wire

/* hdl/isa_ctrl.sv */
// Operation decoder: holds the fill count, steers the cells and forms the result.
`timescale 1ns / 1ps
`default_nettype none

module isa_ctrl
  import isa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [ACTION_W-1:0] action,
  input  wire logic [INDEX_W-1:0]  index,
  input  wire logic [VALUE_W-1:0]  value_in,
  input  word_t                    words [DEPTH],
  output cell_ctrl_t               ctrl [DEPTH],
  output result_t                  result
);

  cnt_t fill_count;
  cnt_t fill_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
    end
  end

  always_comb begin
    logic [CMP_W-1:0] idx;
    logic [CMP_W-1:0] cnt;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] ci;
    logic             full;
    logic             empty;
    logic             do_insert;
    logic             do_set;
    logic             do_remove;
    logic             do_read;
    status_t          status;
    word_t            rd_word;

    idx       = CMP_W'(index);
    cnt       = CMP_W'(fill_count);
    full      = (fill_count == CNT_W'(DEPTH));
    empty     = (fill_count == '0);
    do_insert = 1'b0;
    do_set    = 1'b0;
    do_remove = 1'b0;
    do_read   = 1'b0;
    status    = ST_OK;
    pos       = idx;
    fill_count_next = fill_count;

    unique case (action)
      ACT_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (idx > cnt) begin
          status = ST_RANGE;
        end else begin
          do_insert       = 1'b1;
          fill_count_next = fill_count + 1'b1;
        end
      end
      ACT_SET, ACT_GET, ACT_REMOVE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (idx >= cnt) begin
          status = ST_RANGE;
        end else begin
          do_read = 1'b1;
          if (action == ACT_SET) begin
            do_set = 1'b1;
          end else if (action == ACT_REMOVE) begin
            do_remove       = 1'b1;
            fill_count_next = fill_count - 1'b1;
          end
        end
      end
      ACT_PUSH: begin
        pos = cnt;
        if (full) begin
          status = ST_FULL;
        end else begin
          // A push is an insert at the end of the list.
          do_insert       = 1'b1;
          fill_count_next = fill_count + 1'b1;
        end
      end
      ACT_POP: begin
        pos = cnt - 1'b1;
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_read         = 1'b1;
          fill_count_next = fill_count - 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase

    // Only positions below the fill count are read, so the select is in range.
    rd_word = words[pos[ADDR_W-1:0]];

    for (int i = 0; i < DEPTH; i++) begin
      ci           = CMP_W'(i);
      ctrl[i].op   = CELL_HOLD;
      ctrl[i].load = word_t'(value_in);
      if (accept) begin
        if (do_insert) begin
          if (ci == pos) begin
            ctrl[i].op = CELL_LOAD;
          end else if (ci > pos && ci <= cnt) begin
            ctrl[i].op = CELL_FROM_LO;
          end
        end else if (do_set) begin
          if (ci == pos) begin
            ctrl[i].op = CELL_LOAD;
          end
        end else if (do_remove) begin
          if (ci >= pos && ci + 1'b1 < cnt) begin
            ctrl[i].op = CELL_FROM_HI;
          end
        end
      end
    end

    result.value_out = do_read ? VALUE_W'(rd_word) : '0;
    result.count     = COUNT_W'(fill_count_next);
    result.is_empty  = (fill_count_next == '0);
    result.status    = status;
  end

endmodule

`default_nettype wire

/* hdl/indexed_shift_array.sv */
// Top level of the indexed shift array: stream ports, cell chain and output register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata: action, index, value_in
// m_*       out        m_tvalid / m_tready  m_tdata: value_out, count, is_empty, status
//
// For each accepted word the decoder settles the operation against the
// fill count and the cell chain shifts the affected entries in the same clock edge.
// The result sits in the output register from the cycle after acceptance.
// A new word is accepted while the output register is empty or is being
// drained, so the block holds at most one word and the input stays stalled
// for as long as a result waits on the output.
// Reset (rst, synchronous) clears the fill count and the output valid flag;
// the cell contents are left as they are and are read only once written.

module indexed_shift_array
  import isa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // [2:0] action, [7:3] index, [39:8] value_in
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // [31:0] value_out, [36:32] count, [37] is_empty, [39:38] status
  output logic [OUT_W-1:0]      m_tdata
);

  logic       accept;
  word_t      words [DEPTH];
  cell_ctrl_t ctrl  [DEPTH];
  result_t    result;
  result_t    result_q;
  logic       out_valid;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  isa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .action   (s_tdata[ACTION_W-1:0]),
    .index    (s_tdata[ACTION_W+INDEX_W-1:ACTION_W]),
    .value_in (s_tdata[ACTION_W+INDEX_W+VALUE_W-1:ACTION_W+INDEX_W]),
    .words    (words),
    .ctrl     (ctrl),
    .result   (result)
  );

  // The chain: each cell sees its lower and upper neighbor. The ends take zero,
  // which the decoder never selects.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t lo_word;
    word_t hi_word;

    if (i == 0) begin : g_lo_end
      assign lo_word = '0;
    end else begin : g_lo
      assign lo_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_hi_end
      assign hi_word = '0;
    end else begin : g_hi
      assign hi_word = words[i+1];
    end

    isa_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl[i]),
      .lo_word (lo_word),
      .hi_word (hi_word),
      .word    (words[i])
    );
  end

  // Output register: holds one result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {result_q.status, result_q.is_empty, result_q.count, result_q.value_out};

endmodule

`default_nettype wire
